FILE: hdl/tkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants of the triangular kernel cdf/pdf core.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int SCNT_W = 11;  // sample_count register
  localparam int DELTA_W = 31;  // delta register
  localparam int CDF_W = 27;
  localparam int PDF_W = 32;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 31'd65536;
  localparam logic [CDF_W-1:0] CDF_MAX = {CDF_W{1'b1}};
  localparam logic [PDF_W-1:0] PDF_MAX = {PDF_W{1'b1}};

  // register indexes
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_DELTA = 1'b1;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [9:0]         slot;
    logic signed [31:0] value;
    logic               last_query;
  } in_item_t;

  typedef struct packed {
    logic [10:0]      count_below;
    logic [CDF_W-1:0] cdf_sum;
    logic [PDF_W-1:0] pdf_sum;
    logic             last_result;
  } out_item_t;

  // control that travels along the divider chain
  typedef struct packed {
    logic valid;
    logic full;  // all cells step; otherwise only the upper cells
  } div_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/tkd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_ram
// Single-port ram with registered read data.
// ----------------------------------------------------------------------------
module tkd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hdl/tkd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_div_cell
// One restoring-division step; cells below FRAC_BITS step only on full items.
// ----------------------------------------------------------------------------
module tkd_div_cell
  import tkd_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [DELTA_W-1:0]       divisor,
  input  wire div_ctl_t                 ctl_i,
  input  wire logic [DELTA_W-1:0]       rem_i,
  input  wire logic [2*FRAC_BITS:0]     pend_i,
  input  wire logic [2*FRAC_BITS:0]     quo_i,
  output div_ctl_t                      ctl_o,
  output logic      [DELTA_W-1:0]       rem_o,
  output logic      [2*FRAC_BITS:0]     pend_o,
  output logic      [2*FRAC_BITS:0]     quo_o
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam bit UPPER = (IDX >= FRAC_BITS);

  logic [DELTA_W:0]   trial;
  logic               ge;
  logic               act;
  div_ctl_t           ctl_nxt;
  logic [DELTA_W-1:0] rem_nxt;
  logic [QW-1:0]      pend_nxt;
  logic [QW-1:0]      quo_nxt;

  always_comb begin
    trial = {rem_i, pend_i[QW-1]};
    ge = (trial >= {1'b0, divisor});
    act = ctl_i.full || UPPER;
    ctl_nxt = ctl_i;
    rem_nxt = rem_i;
    pend_nxt = pend_i;
    quo_nxt = quo_i;
    if (act) begin
      rem_nxt = ge ? DELTA_W'(trial - {1'b0, divisor}) : DELTA_W'(trial);
      pend_nxt = {pend_i[QW-2:0], 1'b0};
      quo_nxt = {quo_i[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_nxt;
    end
    rem_o <= rem_nxt;
    pend_o <= pend_nxt;
    quo_o <= quo_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/triangular_kernel_cdf_pdf_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangular_kernel_cdf_pdf_core
// Sorted sample store with binary search and triangular kernel cdf/pdf scan.
// ----------------------------------------------------------------------------
// a query runs a binary search for the first sample not below the window, then scans
// the samples from there, each sample inside the window taking two passes through the
// divider cell chain, until one lies above the window or the store ends; one item at a time
// the result strobe rises in the cycle after the last step and cannot be stalled
// synchronous active-low reset clears control, registers and the chain valid
// bits; the sample store is not cleared
module triangular_kernel_cdf_pdf_core
  import tkd_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = AW + 1;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int NCELL = QW;
  localparam int RW = FRAC_BITS + 1;
  localparam int PSW = ((QW > PDF_W) ? QW : PDF_W) + 1;
  localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BS_RD = 3'd1;
  localparam logic [2:0] ST_BS_CMP = 3'd2;
  localparam logic [2:0] ST_SC_RD = 3'd3;
  localparam logic [2:0] ST_SC_CMP = 3'd4;
  localparam logic [2:0] ST_DIV1 = 3'd5;
  localparam logic [2:0] ST_MUL = 3'd6;
  localparam logic [2:0] ST_DIV2 = 3'd7;

  // configuration
  logic [SCNT_W-1:0]  scnt_r;
  logic [DELTA_W-1:0] delta_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DELTA) ? 32'(delta_r) : 32'(scnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
      delta_r <= DELTA_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SAMPLE_COUNT) begin
        scnt_r <= pwdata[SCNT_W-1:0];
      end else begin
        delta_r <= pwdata[DELTA_W-1:0];
      end
    end
  end

  logic [DELTA_W-1:0] d_eff;
  logic [CW-1:0]      cnt;
  assign d_eff = (delta_r == '0) ? DELTA_W'(1) : delta_r;
  assign cnt = (32'(scnt_r) > 32'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : CW'(scnt_r);

  // query state
  logic [2:0]         state_r, state_nxt;
  logic signed [33:0] q_r, lo_r, hi_r;
  logic               last_r;
  logic [CW-1:0]      first_r, first_nxt;
  logic [CW-1:0]      len_r, len_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      start_r, start_nxt;
  logic               below_r, below_nxt;
  logic [RW-1:0]      r_r, r_nxt;
  logic [RW-1:0]      half_r, half_nxt;
  logic [CDF_W-1:0]   cdf_r, cdf_nxt;
  logic [PDF_W-1:0]   pdf_r, pdf_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic [CW-1:0]      mid;
  logic signed [33:0] s;
  logic [33:0]        t_full;
  logic [2*RW-1:0]    prod;
  logic [RW-1:0]      term_c;
  logic [CDF_W:0]     cdf_add;
  logic [PSW-1:0]     pdf_add;
  logic               accept;

  // sample store
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_rdata;

  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r != ST_IDLE);
  assign ram_we = accept && (in_data.mode == MODE_WRITE) &&
                  (32'(in_data.slot) < 32'(MAX_SAMPLES));
  assign mid = first_r + (len_r >> 1);

  always_comb begin
    if (ram_we) begin
      ram_addr = AW'(in_data.slot);
    end else if (state_r == ST_BS_RD) begin
      ram_addr = mid[AW-1:0];
    end else begin
      ram_addr = j_r[AW-1:0];
    end
  end

  tkd_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_data.value),
    .rdata(ram_rdata)
  );

  // divider cell chain
  div_ctl_t           ctl_w  [NCELL+1];
  logic [DELTA_W-1:0] rem_w  [NCELL+1];
  logic [QW-1:0]      pend_w [NCELL+1];
  logic [QW-1:0]      quo_w  [NCELL+1];
  div_ctl_t           dctl_r, dctl_nxt;
  logic [DELTA_W-1:0] drem_r, drem_nxt;
  logic [QW-1:0]      dpend_r, dpend_nxt;

  assign ctl_w[0] = dctl_r;
  assign rem_w[0] = drem_r;
  assign pend_w[0] = dpend_r;
  assign quo_w[0] = '0;

  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    tkd_div_cell #(
      .FRAC_BITS(FRAC_BITS),
      .IDX      (gi)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .divisor(d_eff),
      .ctl_i  (ctl_w[gi]),
      .rem_i  (rem_w[gi]),
      .pend_i (pend_w[gi]),
      .quo_i  (quo_w[gi]),
      .ctl_o  (ctl_w[gi+1]),
      .rem_o  (rem_w[gi+1]),
      .pend_o (pend_w[gi+1]),
      .quo_o  (quo_w[gi+1])
    );
  end

  always_comb begin
    s = 34'(signed'(ram_rdata));
    t_full = (q_r < s) ? 34'(hi_r - s) : 34'(s - lo_r);
    prod = r_r * r_r;
    // a sample below the window adds a full one
    term_c = (state_r == ST_SC_CMP) ? ONE : (below_r ? half_r : RW'(ONE - half_r));
    cdf_add = (CDF_W + 1)'(cdf_r) + (CDF_W + 1)'(term_c);
    pdf_add = PSW'(pdf_r) + PSW'(quo_w[NCELL]);

    state_nxt = state_r;
    first_nxt = first_r;
    len_nxt = len_r;
    j_nxt = j_r;
    start_nxt = start_r;
    below_nxt = below_r;
    r_nxt = r_r;
    half_nxt = half_r;
    cdf_nxt = cdf_r;
    pdf_nxt = pdf_r;
    ovalid_nxt = 1'b0;
    dctl_nxt = '0;
    drem_nxt = drem_r;
    dpend_nxt = dpend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.mode == MODE_QUERY)) begin
          first_nxt = '0;
          len_nxt = cnt;
          cdf_nxt = '0;
          pdf_nxt = '0;
          state_nxt = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        if (len_r == '0) begin
          j_nxt = first_r;
          start_nxt = first_r;
          state_nxt = ST_SC_RD;
        end else begin
          state_nxt = ST_BS_CMP;
        end
      end
      ST_BS_CMP: begin
        if (s < lo_r) begin
          first_nxt = mid + CW'(1);
          len_nxt = len_r - (len_r >> 1) - CW'(1);
        end else begin
          len_nxt = len_r >> 1;
        end
        state_nxt = ST_BS_RD;
      end
      ST_SC_RD: begin
        if (j_r >= cnt) begin
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SC_CMP;
        end
      end
      ST_SC_CMP: begin
        if (s < lo_r) begin
          // sample fully below the window
          cdf_nxt = (cdf_add > (CDF_W + 1)'(CDF_MAX)) ? CDF_MAX : cdf_add[CDF_W-1:0];
          j_nxt = j_r + CW'(1);
          state_nxt = ST_SC_RD;
        end else if (s > hi_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // ratio t/d: start from t>>1, feed t[0] and the fraction zeros
          below_nxt = (q_r < s);
          dctl_nxt.valid = 1'b1;
          dctl_nxt.full = 1'b0;
          drem_nxt = t_full[DELTA_W:1];
          dpend_nxt = {t_full[0], {(QW - 1){1'b0}}};
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (ctl_w[NCELL].valid) begin
          r_nxt = quo_w[NCELL][RW-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        half_nxt = RW'(prod >> (FRAC_BITS + 1));
        dctl_nxt.valid = 1'b1;
        dctl_nxt.full = 1'b1;
        drem_nxt = '0;
        dpend_nxt = {r_r, {FRAC_BITS{1'b0}}};
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (ctl_w[NCELL].valid) begin
          cdf_nxt = (cdf_add > (CDF_W + 1)'(CDF_MAX)) ? CDF_MAX : cdf_add[CDF_W-1:0];
          pdf_nxt = (pdf_add > PSW'(PDF_MAX)) ? PDF_MAX : pdf_add[PDF_W-1:0];
          j_nxt = j_r + CW'(1);
          state_nxt = ST_SC_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovalid_r <= 1'b0;
      dctl_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      dctl_r <= dctl_nxt;
    end
    if (accept && (in_data.mode == MODE_QUERY)) begin
      q_r <= 34'(in_data.value);
      lo_r <= 34'(in_data.value) - 34'(d_eff);
      hi_r <= 34'(in_data.value) + 34'(d_eff);
      last_r <= in_data.last_query;
    end
    first_r <= first_nxt;
    len_r <= len_nxt;
    j_r <= j_nxt;
    start_r <= start_nxt;
    below_r <= below_nxt;
    r_r <= r_nxt;
    half_r <= half_nxt;
    cdf_r <= cdf_nxt;
    pdf_r <= pdf_nxt;
    drem_r <= drem_nxt;
    dpend_r <= dpend_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data.count_below = 11'(start_r);
  assign out_data.cdf_sum = cdf_r;
  assign out_data.pdf_sum = pdf_r;
  assign out_data.last_result = last_r;

endmodule
`default_nettype wire
